// ===== rtl/lnxq_pkg.sv =====
// Package for the LCD nibble expander queue.
// Request and result payload structs, expander pin map and sizing defaults.
// No dependencies.
package lnxq_pkg;

  localparam int QUEUE_BYTES_DEF = 64;
  localparam int BYTES_PER_PUSH  = 4;

  // Expander bit positions
  localparam int PIN_RS = 0;
  localparam int PIN_RW = 1;
  localparam int PIN_EN = 2;
  localparam int PIN_BL = 3;
  localparam int PIN_D4 = 4;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] cmd_byte;
    logic       reg_select;
    logic       read_write;
  } lnxq_in_t;

  typedef struct packed {
    logic       push_accepted;
    logic       pop_valid;
    logic [7:0] out_byte;
    logic       not_empty;
  } lnxq_out_t;

endpackage

// ===== rtl/lnxq_ring.sv =====
// Byte ring storage for the LCD nibble expander queue.
// One write port, one read port with registered read data.
// Depends on lnxq_pkg for the default depth.
module lnxq_ring #(
  parameter int DEPTH = lnxq_pkg::QUEUE_BYTES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);
  import lnxq_pkg::*;

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lcd_nibble_expander_queue.sv =====
// Top level of the LCD nibble expander queue.
// Control sequencer, ring pointers, result register; instantiates lnxq_ring.
// Depends on lnxq_pkg and lnxq_ring.
//
// A push request splits an LCD command or data byte into four I/O expander
// bytes (high nibble with EN set then clear, low nibble with EN set then
// clear, each carrying RS, RW and the backlight bit) and appends them to a
// ring of QUEUE_BYTES bytes; it is refused when fewer than five free slots
// remain. A pop request returns the oldest expander byte, or zero with
// pop_valid low when the queue is empty. Every request yields one result.
// The block works on one request at a time: a push that fits makes four ring
// writes through the single write port, then the result load; a pop of a
// non-empty queue makes a registered ring read, then the result load; a
// refused push or empty pop goes straight to the result load. A result waits
// in the output register while the next request is taken; the sequencer
// only holds up when a second result is ready before the first one has left.
// The ring needs no clearing after reset.
module lcd_nibble_expander_queue #(
  parameter int QUEUE_BYTES = lnxq_pkg::QUEUE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lnxq_pkg::lnxq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lnxq_pkg::lnxq_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import lnxq_pkg::*;

  localparam int IDX_W     = $clog2(QUEUE_BYTES);
  localparam int CNT_W     = $clog2(QUEUE_BYTES);
  localparam int FIT_LIMIT = QUEUE_BYTES - BYTES_PER_PUSH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_HOLD
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  rd_ptr_r;
  logic [IDX_W-1:0]  wr_ptr_r;
  logic [CNT_W-1:0]  fill_r;
  logic [1:0]        beat_r;
  logic              backlight_r;
  logic [7:0]        cmd_r;
  logic              rs_r;
  logic              rw_r;
  logic              bl_r;
  lnxq_out_t         res_r;
  lnxq_out_t         res_nxt;
  lnxq_out_t         out_data_r;
  logic              out_valid_r;

  logic              in_take;
  logic              fits;
  logic              ring_we;
  logic              ring_re;
  logic [7:0]        wr_byte;
  logic [7:0]        rd_byte;
  logic [3:0]        nibble;
  logic [CNT_W-1:0]  fill_dec;
  logic              out_free;
  logic              load_out;
  logic [IDX_W-1:0]  wr_ptr_inc;
  logic [IDX_W-1:0]  rd_ptr_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign fits     = ({1'b0, fill_r} < (CNT_W+1)'(FIT_LIMIT));
  assign fill_dec = fill_r - CNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_HOLD) && out_free;

  assign wr_ptr_inc = (wr_ptr_r == IDX_W'(QUEUE_BYTES - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
  assign rd_ptr_inc = (rd_ptr_r == IDX_W'(QUEUE_BYTES - 1)) ? '0 : rd_ptr_r + IDX_W'(1);

  // beat 0/1: high nibble, beat 2/3: low nibble; EN set on even beats
  assign nibble = beat_r[1] ? cmd_r[3:0] : cmd_r[7:4];
  always_comb begin
    wr_byte                          = '0;
    wr_byte[PIN_D4 +: 4]             = nibble;
    wr_byte[PIN_RS]                  = rs_r;
    wr_byte[PIN_RW]                  = rw_r;
    wr_byte[PIN_EN]                  = ~beat_r[0];
    wr_byte[PIN_BL]                  = bl_r;
  end

  assign ring_we = (state_r == ST_PUSH);
  assign ring_re = in_take && (in_data.kind == KIND_POP) && (fill_r != '0);

  lnxq_ring #(
    .DEPTH (QUEUE_BYTES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wr_ptr_r),
    .wr_data (wr_byte),
    .rd_en   (ring_re),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_byte)
  );

  always_comb begin
    res_nxt = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res_nxt           = '0;
          res_nxt.not_empty = (fill_r != '0);
        end
      end
      ST_PUSH: begin
        if (beat_r == 2'd3) begin
          res_nxt.push_accepted = 1'b1;
          res_nxt.not_empty     = 1'b1;
        end
      end
      ST_POP: begin
        // ring read data arrives this cycle
        res_nxt.pop_valid = 1'b1;
        res_nxt.out_byte  = rd_byte;
        res_nxt.not_empty = (fill_dec != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b1;
    end else if (cfg_wr_en) begin
      backlight_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      res_r <= res_nxt;
      if (load_out) begin
        out_data_r  <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            cmd_r <= in_data.cmd_byte;
            rs_r  <= in_data.reg_select;
            rw_r  <= in_data.read_write;
            bl_r  <= backlight_r;
            beat_r <= '0;
            if (in_data.kind == KIND_PUSH) begin
              state_r <= fits ? ST_PUSH : ST_HOLD;
            end else begin
              state_r <= (fill_r != '0) ? ST_POP : ST_HOLD;
            end
          end
        end
        ST_PUSH: begin
          wr_ptr_r <= wr_ptr_inc;
          beat_r   <= beat_r + 2'd1;
          if (beat_r == 2'd3) begin
            fill_r  <= fill_r + CNT_W'(BYTES_PER_PUSH);
            state_r <= ST_HOLD;
          end
        end
        ST_POP: begin
          fill_r   <= fill_dec;
          rd_ptr_r <= rd_ptr_inc;
          state_r  <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
